[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, sampled on clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

[src/hevcnal_pkg.sv]
// ----------------------------------------------------------------------------
// hevcnal_pkg
// Types and constants shared by the Annex B NAL classifier modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hevcnal_pkg;

   localparam int unsigned MaxResults = 5;
   localparam int unsigned CountWidth = $clog2(MaxResults + 1);

   localparam logic [7:0] ByteZero  = 8'h00;
   localparam logic [7:0] ByteStart = 8'h01;

   localparam logic [5:0] KindIrapFirst = 6'd19;
   localparam logic [5:0] KindIrapLast  = 6'd21;
   localparam logic [5:0] KindVps       = 6'd32;
   localparam logic [5:0] KindSps       = 6'd33;
   localparam logic [5:0] KindPps       = 6'd34;

   typedef enum logic [1:0] {
      CLASS_OTHER = 2'd0,
      CLASS_VPS   = 2'd1,
      CLASS_SPS   = 2'd2,
      CLASS_PPS   = 2'd3
   } class_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       in_nal;
      logic       nal_first;
      class_type  byte_class;
      logic [5:0] nal_kind;
      logic       unit_end;
      logic       key_unit;
      logic       csd_ready;
   } rsp_item_type;

   typedef struct packed {
      logic                            push;
      logic [CountWidth-1:0]           count;
      rsp_item_type [MaxResults-1:0]   items;
   } batch_type;

endpackage

`default_nettype wire

[src/hevcnal_core.sv]
// ----------------------------------------------------------------------------
// hevcnal_core
// Request register plus start code tracking; turns one request into a batch
// of zero to five tagged results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hevcnal_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire logic [7:0]             req_data_byte,
   input  wire logic                   req_last_byte,
   input  wire logic                   room,
   output      hevcnal_pkg::batch_type batch
);

   logic                    in_valid_ff, in_valid_in;
   logic [7:0]              in_byte_ff;
   logic                    in_last_ff;

   logic [1:0]              zero_cnt_ff, zero_cnt_in;
   logic                    await_ff, await_in;
   hevcnal_pkg::class_type  class_ff, class_in;
   logic [5:0]              kind_ff, kind_in;
   logic                    inside_ff, inside_in;
   logic                    first_done_ff, first_done_in;
   logic                    key_ff, key_in;
   logic [2:0]              seen_ff, seen_in;

   logic                    step_go;
   logic [5:0]              hdr_kind;
   hevcnal_pkg::class_type  hdr_class;
   logic                    key_next;
   logic [2:0]              seen_next;
   logic [2:0]              held_n;
   logic [2:0]              pre_n;
   logic                    pre_start;
   logic                    pre_first;
   logic                    tag_in_nal;
   hevcnal_pkg::class_type  tag_class;
   logic [5:0]              tag_kind;
   logic                    tail_en;
   logic [2:0]              total_n;

   assign req_stall   = in_valid_ff && !room;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;
   assign step_go     = in_valid_ff && room;
   assign hdr_kind    = in_byte_ff[6:1];
   assign held_n      = {1'b0, zero_cnt_ff} + {2'b00, await_ff};

   always_comb begin
      unique case (hdr_kind)
         hevcnal_pkg::KindVps: hdr_class = hevcnal_pkg::CLASS_VPS;
         hevcnal_pkg::KindSps: hdr_class = hevcnal_pkg::CLASS_SPS;
         hevcnal_pkg::KindPps: hdr_class = hevcnal_pkg::CLASS_PPS;
         default:              hdr_class = hevcnal_pkg::CLASS_OTHER;
      endcase
   end

   // step decode and next state
   always_comb begin
      key_next      = key_ff;
      seen_next     = seen_ff;
      pre_n         = 3'd0;
      pre_start     = 1'b0;
      pre_first     = 1'b0;
      tag_in_nal    = inside_ff;
      tag_class     = class_ff;
      tag_kind      = kind_ff;
      tail_en       = 1'b0;
      zero_cnt_in   = zero_cnt_ff;
      await_in      = await_ff;
      class_in      = class_ff;
      kind_in       = kind_ff;
      inside_in     = inside_ff;
      first_done_in = first_done_ff;

      priority if (await_ff) begin
         if (!first_done_ff) begin
            key_next = (hdr_kind >= hevcnal_pkg::KindIrapFirst) &&
                       (hdr_kind <= hevcnal_pkg::KindIrapLast);
         end
         if (key_next && hdr_class != hevcnal_pkg::CLASS_OTHER) begin
            seen_next = seen_ff | (3'b001 << (hdr_class - 2'd1));
         end
         pre_n         = held_n;
         pre_start     = 1'b1;
         pre_first     = 1'b1;
         tag_in_nal    = 1'b1;
         tag_class     = hdr_class;
         tag_kind      = hdr_kind;
         tail_en       = 1'b1;
         zero_cnt_in   = 2'd0;
         await_in      = 1'b0;
         class_in      = hdr_class;
         kind_in       = hdr_kind;
         inside_in     = 1'b1;
         first_done_in = 1'b1;
      end else if (in_byte_ff == hevcnal_pkg::ByteZero) begin
         if (zero_cnt_ff == 2'd3) begin
            pre_n = in_last_ff ? 3'd4 : 3'd1;
         end else begin
            pre_n       = in_last_ff ? {1'b0, zero_cnt_ff} + 3'd1 : 3'd0;
            zero_cnt_in = zero_cnt_ff + 2'd1;
         end
      end else if (in_byte_ff == hevcnal_pkg::ByteStart && zero_cnt_ff >= 2'd2) begin
         pre_n      = in_last_ff ? {1'b0, zero_cnt_ff} + 3'd1 : 3'd0;
         pre_start  = 1'b1;
         pre_first  = 1'b1;
         tag_in_nal = 1'b1;
         tag_class  = hevcnal_pkg::CLASS_OTHER;
         tag_kind   = 6'd0;
         await_in   = 1'b1;
      end else begin
         pre_n       = {1'b0, zero_cnt_ff};
         tail_en     = 1'b1;
         zero_cnt_in = 2'd0;
      end

      if (in_last_ff) begin
         zero_cnt_in   = 2'd0;
         await_in      = 1'b0;
         class_in      = hevcnal_pkg::CLASS_OTHER;
         kind_in       = 6'd0;
         inside_in     = 1'b0;
         first_done_in = 1'b0;
         key_in        = 1'b0;
      end else begin
         key_in        = key_next;
      end
      seen_in = seen_next;
   end

   assign total_n = pre_n + {2'b00, tail_en};

   // assemble the result batch
   always_comb begin
      batch.push  = step_go && total_n != 3'd0;
      batch.count = total_n;
      for (int i = 0; i < hevcnal_pkg::MaxResults; i++) begin
         batch.items[i].out_byte   = hevcnal_pkg::ByteZero;
         batch.items[i].nal_first  = 1'b0;
         batch.items[i].in_nal     = tag_in_nal;
         batch.items[i].byte_class = tag_class;
         batch.items[i].nal_kind   = tag_kind;
         if (3'(i) < pre_n) begin
            if (pre_start && 3'(i) == pre_n - 3'd1) begin
               batch.items[i].out_byte = hevcnal_pkg::ByteStart;
            end
            batch.items[i].nal_first = pre_first && i == 0;
         end else begin
            batch.items[i].out_byte = in_byte_ff;
         end
         batch.items[i].unit_end  = in_last_ff && 3'(i) == total_n - 3'd1;
         batch.items[i].key_unit  = batch.items[i].unit_end && key_next;
         batch.items[i].csd_ready = batch.items[i].unit_end && seen_next == 3'b111;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         zero_cnt_ff   <= 2'd0;
         await_ff      <= 1'b0;
         class_ff      <= hevcnal_pkg::CLASS_OTHER;
         kind_ff       <= 6'd0;
         inside_ff     <= 1'b0;
         first_done_ff <= 1'b0;
         key_ff        <= 1'b0;
         seen_ff       <= 3'b000;
      end else begin
         in_valid_ff <= in_valid_in;
         if (step_go) begin
            zero_cnt_ff   <= zero_cnt_in;
            await_ff      <= await_in;
            class_ff      <= class_in;
            kind_ff       <= kind_in;
            inside_ff     <= inside_in;
            first_done_ff <= first_done_in;
            key_ff        <= key_in;
            seen_ff       <= seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

endmodule

`default_nettype wire

[src/hevcnal_rsp_buf.sv]
// ----------------------------------------------------------------------------
// hevcnal_rsp_buf
// Result queue: takes a batch of up to five results per cycle while it signals
// room, hands out one per cycle on the response channel while rsp_stall is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hevcnal_rsp_buf #(
   parameter int unsigned DepthLog2 = 3
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire hevcnal_pkg::batch_type    batch,
   output      logic                      room,
   output      logic                      rsp_valid,
   input  wire logic                      rsp_stall,
   output      hevcnal_pkg::rsp_item_type rsp_item
);

   localparam int unsigned Depth      = 1 << DepthLog2;
   localparam int unsigned RoomLimit  = Depth - hevcnal_pkg::MaxResults;

   hevcnal_pkg::rsp_item_type mem_ff [Depth];
   logic [DepthLog2-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [DepthLog2-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [DepthLog2:0]        count_ff, count_in;
   logic [DepthLog2:0]        push_n;
   logic                      pop;

   assign rsp_valid = count_ff != '0;
   assign rsp_item  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign room      = count_ff <= (DepthLog2 + 1)'(RoomLimit);
   assign push_n    = batch.push ? (DepthLog2 + 1)'(batch.count) : '0;
   assign wr_ptr_in = wr_ptr_ff + push_n[DepthLog2-1:0];
   assign rd_ptr_in = rd_ptr_ff + DepthLog2'(pop);
   assign count_in  = count_ff + push_n - (DepthLog2 + 1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < hevcnal_pkg::MaxResults; i++) begin
         if (batch.push && hevcnal_pkg::CountWidth'(i) < batch.count) begin
            mem_ff[wr_ptr_ff + DepthLog2'(i)] <= batch.items[i];
         end
      end
   end

endmodule

`default_nettype wire

[src/hevc_annexb_nal_classifier_top.sv]
// Path: requests are registered, then their results go through the result queue;
//   zeros wait for a byte ending the run, start codes for the header or last byte.
// Throughput: one request per cycle on plain data while the result queue has room;
//   one result per cycle out while rsp_stall is low. The 2^BUF_DEPTH_LOG2 entry
//   result queue stalls requests when it cannot take a full batch of five.
// Reset: synchronous; clears all tracking state, sticky seen flags and queue.
// ----------------------------------------------------------------------------
// hevc_annexb_nal_classifier_top
// H.265 Annex B start code parser tagging each byte with its NAL class.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hevc_annexb_nal_classifier_top #(
   parameter int unsigned BUF_DEPTH_LOG2 = 3
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last_byte,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic [7:0] rsp_out_byte,
   output      logic       rsp_in_nal,
   output      logic       rsp_nal_first,
   output      logic [1:0] rsp_byte_class,
   output      logic [5:0] rsp_nal_kind,
   output      logic       rsp_unit_end,
   output      logic       rsp_key_unit,
   output      logic       rsp_csd_ready
);

   hevcnal_pkg::batch_type    batch;
   hevcnal_pkg::rsp_item_type head;
   logic                      room;

   hevcnal_core u_core (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .room          (room),
      .batch         (batch)
   );

   hevcnal_rsp_buf #(
      .DepthLog2 (BUF_DEPTH_LOG2)
   ) u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .batch     (batch),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (head)
   );

   assign rsp_out_byte   = head.out_byte;
   assign rsp_in_nal     = head.in_nal;
   assign rsp_nal_first  = head.nal_first;
   assign rsp_byte_class = head.byte_class;
   assign rsp_nal_kind   = head.nal_kind;
   assign rsp_unit_end   = head.unit_end;
   assign rsp_key_unit   = head.key_unit;
   assign rsp_csd_ready  = head.csd_ready;

   `ASSERT_IMPLIES(a_first_is_zero, rsp_valid && rsp_nal_first,
      rsp_in_nal && rsp_out_byte == hevcnal_pkg::ByteZero, "start code head not a zero in NAL")
   `ASSERT_IMPLIES(a_summary_on_end, rsp_valid && !rsp_unit_end,
      !rsp_key_unit && !rsp_csd_ready, "unit summary outside unit end")
   `ASSERT_ALWAYS(a_batch_bound,
      !batch.push || (batch.count != '0 && batch.count <= 3'(hevcnal_pkg::MaxResults)),
      "result batch size out of range")

endmodule

`default_nettype wire

[tb/sv/tb_hevc_annexb_nal_classifier_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hevc_annexb_nal_classifier_top
// Drives Annex B access units byte by byte into the NAL classifier and checks
// every tagged byte against a predictor kept in step with the accepted
// requests. Directed units cover streams without start codes, long zero runs,
// start codes cut by the end, a parameter set or IRAP NAL first; random units
// follow, with random idling on both sides, one long receiver hold-off, one
// sender pause until all results are back, and a final stretch at full rate.
// ----------------------------------------------------------------------------

module tb_hevc_annexb_nal_classifier_top;

   localparam int LongHoldCycles = 300;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_in_nal;
   logic       rsp_nal_first;
   logic [1:0] rsp_byte_class;
   logic [5:0] rsp_nal_kind;
   logic       rsp_unit_end;
   logic       rsp_key_unit;
   logic       rsp_csd_ready;

   hevc_annexb_nal_classifier_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_in_nal     (rsp_in_nal),
      .rsp_nal_first  (rsp_nal_first),
      .rsp_byte_class (rsp_byte_class),
      .rsp_nal_kind   (rsp_nal_kind),
      .rsp_unit_end   (rsp_unit_end),
      .rsp_key_unit   (rsp_key_unit),
      .rsp_csd_ready  (rsp_csd_ready)
   );

   always #5 clock = ~clock;

   // predictor state
   int                        zeros_in_run = 0;
   logic [7:0]                held_byte [4];
   int                        held_count = 0;
   logic                      header_due = 1'b0;
   hevcnal_pkg::class_type    nal_class = hevcnal_pkg::CLASS_OTHER;
   logic [5:0]                nal_type = 6'd0;
   logic                      in_nal_now = 1'b0;
   logic                      first_nal_seen = 1'b0;
   logic                      unit_key = 1'b0;
   logic [2:0]                sets_seen = 3'b000;

   hevcnal_pkg::rsp_item_type step_res [hevcnal_pkg::MaxResults];
   int                        step_n;
   hevcnal_pkg::rsp_item_type expected_tags [$];

   logic [7:0]   unit_bytes [$];
   int           requests_sent = 0;
   int           mismatches = 0;
   logic         req_idle_on = 1'b1;
   logic         rsp_idle_on = 1'b1;
   int           long_hold_asks = 0;
   int           long_hold_done = 0;
   int           hold_left = 0;
   int           burst_left = 0;

   function automatic void add_result(logic [7:0] b, logic opens, logic in_flag,
                                      hevcnal_pkg::class_type c, logic [5:0] k);
      hevcnal_pkg::rsp_item_type r;
      r = '0;
      r.out_byte   = b;
      r.in_nal     = in_flag;
      r.nal_first  = opens;
      r.byte_class = c;
      r.nal_kind   = k;
      if (step_n < hevcnal_pkg::MaxResults) begin
         step_res[step_n] = r;
         step_n++;
      end
   endfunction

   function automatic void release_held();
      for (int i = 0; i < held_count; i++)
         add_result(held_byte[i], 1'b0, in_nal_now, nal_class, nal_type);
      held_count = 0;
      zeros_in_run = 0;
   endfunction

   task automatic classify_request(input logic [7:0] b, input logic is_last);
      logic [5:0]             k;
      hevcnal_pkg::class_type c;
      step_n = 0;
      if (header_due) begin
         k = b[6:1];
         c = hevcnal_pkg::CLASS_OTHER;
         if (k == hevcnal_pkg::KindVps) c = hevcnal_pkg::CLASS_VPS;
         else if (k == hevcnal_pkg::KindSps) c = hevcnal_pkg::CLASS_SPS;
         else if (k == hevcnal_pkg::KindPps) c = hevcnal_pkg::CLASS_PPS;
         if (!first_nal_seen) begin
            unit_key = (k >= hevcnal_pkg::KindIrapFirst && k <= hevcnal_pkg::KindIrapLast);
            first_nal_seen = 1'b1;
         end
         if (unit_key && c != hevcnal_pkg::CLASS_OTHER)
            sets_seen = sets_seen | (3'b001 << (int'(c) - 1));
         nal_class  = c;
         nal_type   = k;
         in_nal_now = 1'b1;
         for (int i = 0; i < held_count; i++)
            add_result(held_byte[i], i == 0, 1'b1, c, k);
         add_result(b, 1'b0, 1'b1, c, k);
         held_count   = 0;
         zeros_in_run = 0;
         header_due   = 1'b0;
      end else if (b == hevcnal_pkg::ByteZero) begin
         // a fourth zero pushes the oldest out with the current tag
         if (held_count >= 3) begin
            add_result(held_byte[0], 1'b0, in_nal_now, nal_class, nal_type);
            held_byte[0] = held_byte[1];
            held_byte[1] = held_byte[2];
            held_count = 2;
         end
         held_byte[held_count] = hevcnal_pkg::ByteZero;
         held_count++;
         zeros_in_run = held_count;
      end else if (b == hevcnal_pkg::ByteStart && zeros_in_run >= 2) begin
         held_byte[held_count] = hevcnal_pkg::ByteStart;
         held_count++;
         zeros_in_run = 0;
         header_due = 1'b1;
      end else begin
         release_held();
         add_result(b, 1'b0, in_nal_now, nal_class, nal_type);
      end
      if (is_last) begin
         // flush a start code cut by the end as an untyped NAL
         if (header_due) begin
            for (int i = 0; i < held_count; i++)
               add_result(held_byte[i], i == 0, 1'b1, hevcnal_pkg::CLASS_OTHER, 6'd0);
            held_count   = 0;
            zeros_in_run = 0;
         end else begin
            release_held();
         end
         if (step_n > 0) begin
            step_res[step_n-1].unit_end  = 1'b1;
            step_res[step_n-1].key_unit  = unit_key;
            step_res[step_n-1].csd_ready = (sets_seen == 3'b111);
         end
         header_due     = 1'b0;
         nal_class      = hevcnal_pkg::CLASS_OTHER;
         nal_type       = 6'd0;
         in_nal_now     = 1'b0;
         first_nal_seen = 1'b0;
         unit_key       = 1'b0;
      end
      for (int i = 0; i < step_n; i++)
         expected_tags.push_back(step_res[i]);
   endtask

   function automatic string show_result(hevcnal_pkg::rsp_item_type r);
      return $sformatf("byte %h in_nal %b first %b class %0d kind %0d end %b key %b csd %b",
                       r.out_byte, r.in_nal, r.nal_first, r.byte_class, r.nal_kind,
                       r.unit_end, r.key_unit, r.csd_ready);
   endfunction

   always @(posedge clock) begin
      hevcnal_pkg::rsp_item_type got;
      hevcnal_pkg::rsp_item_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got.out_byte   = rsp_out_byte;
         got.in_nal     = rsp_in_nal;
         got.nal_first  = rsp_nal_first;
         got.byte_class = hevcnal_pkg::class_type'(rsp_byte_class);
         got.nal_kind   = rsp_nal_kind;
         got.unit_end   = rsp_unit_end;
         got.key_unit   = rsp_key_unit;
         got.csd_ready  = rsp_csd_ready;
         if (expected_tags.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: %s", show_result(got));
         end else begin
            want = expected_tags.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: expected %s", show_result(want));
                  $display("          actual   %s", show_result(got));
               end
            end
         end
      end
   end

   // receiver: random stall bursts, plus a long hold-off on request
   always @(posedge clock) begin
      if (long_hold_done != long_hold_asks) begin
         long_hold_done <= long_hold_asks;
         hold_left <= LongHoldCycles;
         rsp_stall <= 1'b1;
      end else if (hold_left > 1) begin
         hold_left <= hold_left - 1;
      end else if (hold_left == 1) begin
         hold_left <= 0;
         rsp_stall <= 1'b0;
      end else if (!rsp_idle_on) begin
         rsp_stall <= 1'b0;
      end else if (burst_left > 0) begin
         burst_left <= burst_left - 1;
      end else begin
         rsp_stall  <= ($urandom_range(0, 2) == 0);
         burst_left <= $urandom_range(0, 9);
      end
   end

   task automatic send_request(input logic [7:0] b, input logic is_last);
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= is_last;
      do @(posedge clock); while (req_stall !== 1'b0);
      classify_request(b, is_last);
      requests_sent++;
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic send_unit();
      for (int i = 0; i < unit_bytes.size(); i++)
         send_request(unit_bytes[i], i == unit_bytes.size() - 1);
   endtask

   task automatic release_req();
      req_valid <= 1'b0;
   endtask

   task automatic wait_for_results();
      while (expected_tags.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] payload_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return 8'h00;
      if (r == 4) return 8'h01;
      if (r == 5) return 8'h03;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic add_start_code();
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 2)) unit_bytes.push_back(8'h00);
      unit_bytes.push_back(8'h00);
      unit_bytes.push_back(8'h00);
      if ($urandom_range(0, 1) == 1) unit_bytes.push_back(8'h00);
      unit_bytes.push_back(8'h01);
   endtask

   task automatic build_unit();
      int         shape;
      int         r;
      logic [5:0] k;
      logic [7:0] hdr;
      unit_bytes.delete();
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
         repeat ($urandom_range(1, 6)) unit_bytes.push_back(payload_byte());
      end else begin
         if ($urandom_range(0, 4) == 0) unit_bytes.push_back(payload_byte());
         for (int n = 0; n < $urandom_range(1, 4); n++) begin
            add_start_code();
            r = $urandom_range(0, 9);
            if (n == 0 && r < 5) k = 6'($urandom_range(19, 21));
            else case (r)
               0, 1:    k = 6'($urandom_range(19, 21));
               2:       k = hevcnal_pkg::KindVps;
               3:       k = hevcnal_pkg::KindSps;
               4:       k = hevcnal_pkg::KindPps;
               5:       k = 6'($urandom_range(0, 18));
               6:       k = 6'($urandom_range(22, 31));
               7:       k = 6'($urandom_range(35, 63));
               default: k = 6'($urandom_range(0, 63));
            endcase
            hdr = 8'($urandom_range(0, 255));
            hdr[6:1] = k;
            unit_bytes.push_back(hdr);
            unit_bytes.push_back(8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 4)) unit_bytes.push_back(payload_byte());
         end
         // end on a start code with no header
         if (shape == 1) add_start_code();
      end
   endtask

   task automatic send_random_units(input int count);
      int stop_at;
      stop_at = requests_sent + count;
      while (requests_sent < stop_at) begin
         build_unit();
         send_unit();
      end
   endtask

   task automatic test_no_start_code();
      unit_bytes = {8'hFF, 8'h00, 8'h01};
      send_unit();
   endtask

   task automatic test_parameter_set_first();
      // VPS first, then a long zero run and a start code cut by the end
      unit_bytes = {8'h00, 8'h00, 8'h01, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01};
      send_unit();
   endtask

   task automatic test_key_unit();
      // IRAP first, a header byte of zero that starts no start code, then a VPS
      unit_bytes = {8'h00, 8'h00, 8'h00, 8'h01, 8'h2A,
                    8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01,
                    8'h00, 8'h00, 8'h01, 8'hC1, 8'hFF};
      send_unit();
   endtask

   task automatic test_random_units();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      send_random_units(10);
   endtask

   task automatic test_backpressure();
      req_idle_on = 1'b0;
      long_hold_asks++;
      send_random_units(12);
      req_idle_on = 1'b1;
   endtask

   task automatic test_sender_pause();
      build_unit();
      send_unit();
      release_req();
      wait_for_results();
      build_unit();
      send_unit();
   endtask

   task automatic test_steady_stream();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      send_random_units(10);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_no_start_code();
      test_parameter_set_first();
      test_key_unit();
      test_random_units();
      test_backpressure();
      test_sender_pause();
      test_steady_stream();
      release_req();
      wait_for_results();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_tags.size() == 0) begin
         $display("hevc_annexb_nal_classifier_top regression: pass");
      end else begin
         $display("hevc_annexb_nal_classifier_top regression: fail");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("hevc_annexb_nal_classifier_top regression: fail");
      $finish;
   end

endmodule
